// ===== hw/rtl/llu_pkg.sv =====
// Package: shared types, constants and helpers of the Langevin leapfrog update block.
`timescale 1ns / 1ps
package llu_pkg;

    localparam int MaxAtomsDef = 65536;
    localparam int Components  = 3;
    localparam int CntW        = 18;
    localparam int QueueDepth  = 4;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 32;

    // Register indexes
    localparam logic [CfgIdxW-1:0] RegVelScale   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegForceScale = 3'd1;
    localparam logic [CfgIdxW-1:0] RegNoiseScale = 3'd2;
    localparam logic [CfgIdxW-1:0] RegStepSize   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegAtomCount  = 3'd4;

    // Classified word handed from front to back
    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] force_req;
        logic        [31:0] inverse_mass;
        logic signed [15:0] noise_sample;
        logic               fixed_atom;
        logic               last_item;
    } t_item;

    // Scale factors used by the back end
    typedef struct packed {
        logic [31:0] vel_scale;
        logic [31:0] force_scale;
        logic [31:0] noise_scale;
        logic [31:0] step_size;
    } t_scale;

    // Square root iteration state
    typedef struct packed {
        logic [31:0] rem;
        logic [27:0] root;
        logic [55:0] rad;
    } t_sqrt;

    // One restoring square root step: take the next radicand bit pair
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        logic [31:0] r2;
        logic [31:0] trial;
        t_sqrt       o;
        r2    = {s.rem[29:0], s.rad[55:54]};
        trial = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[53:0], 2'b00};
        if (r2 >= trial) begin
            o.rem  = r2 - trial;
            o.root = {s.root[26:0], 1'b1};
        end else begin
            o.rem  = r2;
            o.root = {s.root[26:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== hw/rtl/llu_in_if.sv =====
// Interface: input channel carrying one atom component word.
`timescale 1ns / 1ps
interface llu_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] force_req;
    logic        [31:0] inverse_mass;
    logic signed [15:0] noise_sample;

    modport source (output valid, position, velocity, force_req, inverse_mass,
                    noise_sample, input ready);
    modport sink   (input valid, position, velocity, force_req, inverse_mass,
                    noise_sample, output ready);
endinterface

// ===== hw/rtl/llu_out_if.sv =====
// Interface: output channel carrying one updated component word.
`timescale 1ns / 1ps
interface llu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
    logic               fixed_atom;
    logic               saturated;
    logic               last_item;

    modport source (output valid, new_position, new_velocity, fixed_atom, saturated,
                    last_item, input ready);
    modport sink   (input valid, new_position, new_velocity, fixed_atom, saturated,
                    last_item, output ready);
endinterface

// ===== hw/rtl/llu_front.sv =====
// Front end: accept words, flag fixed atoms and mark the last component of a pass.
`timescale 1ns / 1ps
module llu_front #(
    parameter int MAX_ATOMS = llu_pkg::MaxAtomsDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [16:0]    i_atom_count,
    llu_in_if.sink         i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output llu_pkg::t_item o_item
);
    localparam logic [24:0] MaxA = 25'(MAX_ATOMS);

    logic [llu_pkg::CntW-1:0] r_cnt, n_cnt;
    logic [24:0]              w_atoms;
    logic [26:0]              w_last_idx;
    logic                     w_last;

    // Clamp the atom count and find the last index of the pass
    always_comb begin
        w_atoms = {8'd0, i_atom_count};
        if (w_atoms == 25'd0) w_atoms = 25'd1;
        if (w_atoms > MaxA)   w_atoms = MaxA;
        w_last_idx = 27'(w_atoms) * 27'(llu_pkg::Components) - 27'd1;
        w_last     = 27'(r_cnt) >= w_last_idx;
    end

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // Classify the word
    always_comb begin
        o_item.position     = i_in.position;
        o_item.velocity     = i_in.velocity;
        o_item.force_req    = i_in.force_req;
        o_item.inverse_mass = i_in.inverse_mass;
        o_item.noise_sample = i_in.noise_sample;
        o_item.fixed_atom   = i_in.inverse_mass == 32'd0;
        o_item.last_item    = w_last;
    end

    // Advance the component counter on each accepted word
    always_comb begin
        n_cnt = r_cnt;
        if (o_push) n_cnt = w_last ? '0 : r_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else          r_cnt <= n_cnt;
    end
endmodule

// ===== hw/rtl/llu_queue.sv =====
// Queue: short register FIFO between the front and back ends.
`timescale 1ns / 1ps
module llu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  llu_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output llu_pkg::t_item o_item
);
    localparam int AW = $clog2(llu_pkg::QueueDepth);

    llu_pkg::t_item r_mem [llu_pkg::QueueDepth];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = r_cnt == (AW+1)'(llu_pkg::QueueDepth);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rp];

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

// ===== hw/rtl/llu_back.sv =====
// Back end: pipelined velocity and position update with saturation.
`timescale 1ns / 1ps
module llu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  llu_pkg::t_scale i_scale,
    input  logic           i_q_empty,
    input  llu_pkg::t_item i_item,
    output logic           o_pop,
    llu_out_if.source      o_out
);
    localparam int NStg = 20;

    typedef struct packed {
        llu_pkg::t_item     it;
        logic signed [64:0] pa;
        logic        [63:0] pfm;
        logic signed [33:0] a;
        logic signed [64:0] pb;
        llu_pkg::t_sqrt     sq;
        logic        [59:0] pn;
        logic signed [48:0] pc;
        logic signed [31:0] nv;
        logic               clip;
        logic signed [64:0] pp;
        logic signed [31:0] nx;
    } t_stg;

    t_stg r_stg [NStg];
    t_stg n_stg [NStg];
    logic [NStg-1:0] r_vld;
    logic            w_en;

    // Whole pipe advances unless the output word is held
    assign w_en  = !r_vld[NStg-1] || o_out.ready;
    assign o_pop = w_en && !i_q_empty;

    always_comb begin
        logic signed [53:0] sum;
        logic signed [37:0] px;
        sum = '0;
        px  = '0;
        for (int k = 0; k < NStg; k++) begin
            n_stg[k] = r_stg[(k == 0) ? 0 : k-1];
            if (k == 0) begin
                // Decay and force factor products
                n_stg[0].it  = i_item;
                n_stg[0].pa  = $signed({{33{i_item.velocity[31]}}, i_item.velocity})
                             * $signed({33'd0, i_scale.vel_scale});
                n_stg[0].pfm = {32'd0, i_scale.force_scale} * {32'd0, i_item.inverse_mass};
            end
            if (k == 1) begin
                // Decayed velocity, force term product, start the root
                n_stg[1].a  = 34'(r_stg[0].pa >>> 31);
                n_stg[1].pb = $signed({{33{r_stg[0].it.force_req[31]}}, r_stg[0].it.force_req})
                            * $signed({33'd0, r_stg[0].pfm[63:32]});
                n_stg[1].sq.rem  = '0;
                n_stg[1].sq.root = '0;
                n_stg[1].sq.rad  = {r_stg[0].it.inverse_mass, 24'd0};
            end
            if (k >= 1 && k <= 14) begin
                // Two root bits per stage
                n_stg[k].sq = llu_pkg::sqrt_step(llu_pkg::sqrt_step(n_stg[k].sq));
            end
            if (k == 15) begin
                n_stg[15].pn = {28'd0, i_scale.noise_scale} * {32'd0, r_stg[14].sq.root};
            end
            if (k == 16) begin
                n_stg[16].pc = $signed({{33{r_stg[15].it.noise_sample[15]}},
                                        r_stg[15].it.noise_sample})
                             * $signed({17'd0, r_stg[15].pn[59:28]});
            end
            if (k == 17) begin
                // Sum the terms and clip the velocity
                sum = 54'(r_stg[16].a) + 54'(r_stg[16].pb >>> 12) + 54'(r_stg[16].pc >>> 12);
                n_stg[17].clip = 1'b0;
                if (sum > 54'sh7FFFFFFF) begin
                    n_stg[17].nv   = 32'sh7FFFFFFF;
                    n_stg[17].clip = 1'b1;
                end else if (sum < -54'sh80000000) begin
                    n_stg[17].nv   = 32'sh80000000;
                    n_stg[17].clip = 1'b1;
                end else begin
                    n_stg[17].nv = 32'(sum);
                end
            end
            if (k == 18) begin
                n_stg[18].pp = $signed({{33{r_stg[17].nv[31]}}, r_stg[17].nv})
                             * $signed({33'd0, i_scale.step_size});
            end
            if (k == 19) begin
                // Advance the position and clip it
                px = 38'(r_stg[18].it.position) + 38'(r_stg[18].pp >>> 28);
                if (px > 38'sh7FFFFFFF) begin
                    n_stg[19].nx   = 32'sh7FFFFFFF;
                    n_stg[19].clip = 1'b1;
                end else if (px < -38'sh80000000) begin
                    n_stg[19].nx   = 32'sh80000000;
                    n_stg[19].clip = 1'b1;
                end else begin
                    n_stg[19].nx = 32'(px);
                end
                // Pass fixed atoms through unchanged
                if (r_stg[18].it.fixed_atom) begin
                    n_stg[19].nx   = r_stg[18].it.position;
                    n_stg[19].nv   = r_stg[18].it.velocity;
                    n_stg[19].clip = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NStg; k++) r_stg[k] <= n_stg[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[NStg-2:0], !i_q_empty};
    end

    assign o_out.valid        = r_vld[NStg-1];
    assign o_out.new_position = r_stg[NStg-1].nx;
    assign o_out.new_velocity = r_stg[NStg-1].nv;
    assign o_out.fixed_atom   = r_stg[NStg-1].it.fixed_atom;
    assign o_out.saturated    = r_stg[NStg-1].clip;
    assign o_out.last_item    = r_stg[NStg-1].it.last_item;
endmodule

// ===== hw/rtl/langevin_leapfrog_update_top.sv =====
// Top level: Langevin leapfrog update with configuration registers.
//
// Usage: write the scale factors, step and atom count through i_cfg_we,
// i_cfg_idx and i_cfg_data while the block is idle. Stream one Cartesian
// component per word on i_in (valid/ready); one updated word per input
// leaves on o_out in the same order, with fixed-atom, clip and
// last-of-pass flags.
// Throughput: one word per cycle while the receiver does not stall o_out.
// Words pass through the queue, the 14-stage square root pipe (two root
// bits a stage) and the chained products after it to reach o_out.
// A four-word queue parts the front end from the arithmetic pipe; when the
// receiver stalls the pipe holds and the queue fills, after which i_in.ready
// drops. Reset (i_rst_n low at a clock edge) empties the queue and pipe,
// zeroes the component counter and restores the register defaults
// (decay factor one, other factors zero, one atom).
`timescale 1ns / 1ps
module langevin_leapfrog_update_top #(
    parameter int MAX_ATOMS = llu_pkg::MaxAtomsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [llu_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [llu_pkg::CfgDataW-1:0] i_cfg_data,
    llu_in_if.sink                       i_in,
    llu_out_if.source                    o_out
);
    llu_pkg::t_scale r_scale;
    logic [16:0]     r_atoms;
    logic            w_push, w_pop, w_full, w_empty;
    llu_pkg::t_item  w_fitem, w_qitem;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale.vel_scale   <= 32'h8000_0000;
            r_scale.force_scale <= '0;
            r_scale.noise_scale <= '0;
            r_scale.step_size   <= '0;
            r_atoms             <= 17'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                llu_pkg::RegVelScale:   r_scale.vel_scale   <= i_cfg_data;
                llu_pkg::RegForceScale: r_scale.force_scale <= i_cfg_data;
                llu_pkg::RegNoiseScale: r_scale.noise_scale <= i_cfg_data;
                llu_pkg::RegStepSize:   r_scale.step_size   <= i_cfg_data;
                llu_pkg::RegAtomCount:  r_atoms             <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    llu_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_atom_count (r_atoms),
        .i_in         (i_in),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_item       (w_fitem)
    );

    llu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_qitem)
    );

    llu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_scale   (r_scale),
        .i_q_empty (w_empty),
        .i_item    (w_qitem),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );
endmodule

// ===== sim/langevin_leapfrog_update_top_tb.sv =====
// Testbench: Langevin leapfrog update top, self-checking against an internal predictor.
`timescale 1ns / 1ps
module langevin_leapfrog_update_top_tb;

    // index with no register behind it; writes there must change nothing
    localparam logic [llu_pkg::CfgIdxW-1:0] RegUnmapped = 3'd7;
    localparam int                 DrainCycles = 30;
    localparam int                 StallLimit  = 4000;
    localparam int                 RandomWords = 1350;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] force_req;
        logic        [31:0] inverse_mass;
        logic signed [15:0] noise_sample;
    } t_component;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic               fixed_atom;
        logic               saturated;
        logic               last_item;
    } t_update;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [llu_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [llu_pkg::CfgDataW-1:0] i_cfg_data;

    llu_in_if  in_ch ();
    llu_out_if out_ch ();

    langevin_leapfrog_update_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // shadow registers and pass counter of the predictor
    logic [31:0] sh_vel_scale;
    logic [31:0] sh_force_scale;
    logic [31:0] sh_noise_scale;
    logic [31:0] sh_step_size;
    logic [16:0] sh_atom_count;
    logic [17:0] sh_component_cnt;

    t_update     pending_updates[$];
    int          err_count   = 0;
    bit          idle_on     = 1'b1;
    bit          in_taken;
    bit          out_taken;
    int          quiet_cycles = 0;
    int          ready_hold   = 0;

    // floor of the square root of a 56-bit value, one root bit at a time
    function automatic logic [27:0] sqrt_floor(input logic [55:0] radicand);
        logic [27:0] root;
        logic [27:0] cand;
        root = '0;
        for (int i = 27; i >= 0; i--) begin
            cand = root | (28'd1 << i);
            if ({28'd0, cand} * {28'd0, cand} <= {8'd0, radicand}) root = cand;
        end
        return root;
    endfunction

    function automatic longint clip32(input longint val, inout bit hit);
        if (val > 64'sd2147483647) begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (val < -64'sd2147483648) begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return val;
    endfunction

    // work out the updated component and advance the pass counter
    function automatic t_update leapfrog_update(input t_component c);
        t_update     u;
        longint      vel;
        longint      pos;
        longint      fs_m;
        longint      ns_r;
        longint      term_v;
        longint      term_f;
        longint      term_n;
        bit          hit;
        logic [27:0] root;
        logic [17:0] last_idx;
        logic [16:0] atoms;
        hit = 1'b0;
        if (c.inverse_mass == 0) begin
            pos = c.position;
            vel = c.velocity;
        end else begin
            term_v = (longint'(c.velocity) * longint'({32'd0, sh_vel_scale})) >>> 31;
            fs_m   = longint'(({32'd0, sh_force_scale} * {32'd0, c.inverse_mass}) >> 32);
            term_f = (longint'(c.force_req) * fs_m) >>> 12;
            root   = sqrt_floor({c.inverse_mass, 24'd0});
            ns_r   = longint'(({32'd0, sh_noise_scale} * {36'd0, root}) >> 28);
            term_n = (longint'(c.noise_sample) * ns_r) >>> 12;
            vel    = clip32(term_v + term_f + term_n, hit);
            pos    = clip32(longint'(c.position)
                            + ((vel * longint'({32'd0, sh_step_size})) >>> 28), hit);
        end
        atoms = sh_atom_count;
        if (atoms == 0) atoms = 17'd1;
        if (atoms > 17'd65536) atoms = 17'd65536;
        last_idx = 18'(atoms * 3 - 1);
        u.last_item = (sh_component_cnt >= last_idx);
        sh_component_cnt = u.last_item ? 18'd0 : sh_component_cnt + 18'd1;
        u.new_position = pos[31:0];
        u.new_velocity = vel[31:0];
        u.fixed_atom   = (c.inverse_mass == 0);
        u.saturated    = hit;
        return u;
    endfunction

    // write one register, then release the write port
    task automatic cfg_write(input logic [llu_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            llu_pkg::RegVelScale:   sh_vel_scale   = data;
            llu_pkg::RegForceScale: sh_force_scale = data;
            llu_pkg::RegNoiseScale: sh_noise_scale = data;
            llu_pkg::RegStepSize:   sh_step_size   = data;
            llu_pkg::RegAtomCount:  sh_atom_count  = data[16:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic cfg_all(input logic [31:0] vs, input logic [31:0] fs,
                           input logic [31:0] ns, input logic [31:0] st,
                           input logic [31:0] na);
        cfg_write(llu_pkg::RegVelScale, vs);
        cfg_write(llu_pkg::RegForceScale, fs);
        cfg_write(llu_pkg::RegNoiseScale, ns);
        cfg_write(llu_pkg::RegStepSize, st);
        cfg_write(llu_pkg::RegAtomCount, na);
    endtask

    // drop valid, hold until every update is back, then let the pipe settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // offer one word; predict it once it is certain to be taken
    task automatic send_component(input t_component c);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.position     <= c.position;
        in_ch.velocity     <= c.velocity;
        in_ch.force_req    <= c.force_req;
        in_ch.inverse_mass <= c.inverse_mass;
        in_ch.noise_sample <= c.noise_sample;
        forever begin
            @(negedge i_clk);
            if (in_ch.ready) break;
            @(posedge i_clk);
        end
        pending_updates.push_back(leapfrog_update(c));
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 4000)) - 2000);
            3, 4: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_component pick_component();
        t_component c;
        c.position     = pick_word();
        c.velocity     = pick_word();
        c.force_req    = pick_word();
        case ($urandom_range(0, 7))
            0: c.inverse_mass = '0;
            1: c.inverse_mass = 32'hFFFF_FFFF;
            2, 3: c.inverse_mass = $urandom_range(1, 1 << 26);
            default: c.inverse_mass = $urandom;
        endcase
        c.noise_sample = 16'($urandom);
        return c;
    endfunction

    function automatic t_component mk(input logic [31:0] x, input logic [31:0] v,
                                      input logic [31:0] f, input logic [31:0] m,
                                      input logic [15:0] n);
        t_component c;
        c = '{x, v, f, m, n};
        return c;
    endfunction

    // extremes, fixed atoms, clipping, odd atom counts and the counter overrun
    task automatic test_directed();
        cfg_all(32'h8000_0000, 32'h1000_0000, 32'h0100_0000, 32'h0010_0000, 32'd2);
        send_component(mk(32'd0, 32'd0, 32'd0, 32'd0, 16'd0));
        send_component(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'h7FFF));
        send_component(mk(32'h0010_0000, 32'h0010_0000, 32'h0000_1000, 32'h0100_0000, 16'h1000));
        send_component(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF));
        send_component(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 16'h8000));
        send_component(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 16'hFFFF));
        drain();
        cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        cfg_write(RegUnmapped, 32'hDEAD_BEEF);
        send_component(mk(32'd5, 32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 16'h0100));
        send_component(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h8000));
        send_component(mk(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 16'h5A5A));
        send_component(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0, 16'd0));
        drain();
        // oversized atom count, then lower it mid-pass so the counter overruns
        cfg_all(32'h0000_0000, 32'd0, 32'd0, 32'd0, 32'h1FFFF);
        repeat (5) send_component(pick_component());
        drain();
        cfg_write(llu_pkg::RegAtomCount, 32'd1);
        repeat (5) send_component(pick_component());
        drain();
    endtask

    // several register settings, each followed by a run of random words
    task automatic test_random(input int words);
        int left;
        int burst;
        left = words;
        while (left > 0) begin
            case ($urandom_range(0, 5))
                0: cfg_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
                1: cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'd65536);
                default: cfg_all($urandom_range(0, 32'h8000_0000),
                                 $urandom_range(0, 1 << 29), $urandom_range(0, 1 << 26),
                                 $urandom_range(0, 1 << 25), $urandom_range(0, 6));
            endcase
            burst = $urandom_range(60, 200);
            if (burst > left) burst = left;
            for (int i = 0; i < burst; i++) send_component(pick_component());
            left -= burst;
            drain();
        end
    endtask

    // receiver: stall in short random bursts while idling is on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold   = ready_hold - 1;
            out_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            ready_hold   = $urandom_range(0, 3);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // compare each word that will be taken at the next edge
    always @(negedge i_clk) begin
        t_update want;
        in_taken  = i_rst_n && in_ch.valid && in_ch.ready;
        out_taken = i_rst_n && out_ch.valid && out_ch.ready;
        if (out_taken) begin
            if (pending_updates.size() == 0) begin
                $error("unexpected word: pos %h vel %h", out_ch.new_position,
                       out_ch.new_velocity);
                err_count++;
            end else begin
                want = pending_updates.pop_front();
                if (out_ch.new_position !== want.new_position) begin
                    $error("new_position exp %h got %h", want.new_position,
                           out_ch.new_position);
                    err_count++;
                end
                if (out_ch.new_velocity !== want.new_velocity) begin
                    $error("new_velocity exp %h got %h", want.new_velocity,
                           out_ch.new_velocity);
                    err_count++;
                end
                if (out_ch.fixed_atom !== want.fixed_atom) begin
                    $error("fixed_atom exp %b got %b", want.fixed_atom, out_ch.fixed_atom);
                    err_count++;
                end
                if (out_ch.saturated !== want.saturated) begin
                    $error("saturated exp %b got %b", want.saturated, out_ch.saturated);
                    err_count++;
                end
                if (out_ch.last_item !== want.last_item) begin
                    $error("last_item exp %b got %b", want.last_item, out_ch.last_item);
                    err_count++;
                end
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (in_taken || out_taken || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.position     <= '0;
        in_ch.velocity     <= '0;
        in_ch.force_req    <= '0;
        in_ch.inverse_mass <= '0;
        in_ch.noise_sample <= '0;
        sh_vel_scale     = 32'h8000_0000;
        sh_force_scale   = '0;
        sh_noise_scale   = '0;
        sh_step_size     = '0;
        sh_atom_count    = 17'd1;
        sh_component_cnt = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(RandomWords - 300);
        // last stretch at full rate on both sides
        idle_on = 1'b0;
        test_random(300);
        drain();
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
